>>> src/r2p_pkg.sv
`timescale 1ns / 1ps
// r2p_pkg: shared constants and types for the rectangular-to-polar converter.
// Holds the CORDIC arctangent table in turn units and the pipeline sizing constants.
// No dependencies.

package r2p_pkg;

    // Number of CORDIC micro-rotations; the phase accumulator is 32 bits wide
    localparam int CORDIC_STEPS  = 32;
    // Fractional bits added to x and y before the rotations
    localparam int PRESCALE_BITS = 24;
    // Guard bits above the prescaled input for negation and CORDIC gain
    localparam int HEADROOM_BITS = 3;

    // Phase accumulator: unsigned fraction of a turn, 2^32 = full turn
    typedef logic [31:0] turn_t;

    localparam turn_t ACC_HALF_TURN = 32'h8000_0000;

    // round(atan(2^-i) / (2*pi) * 2^32)
    localparam turn_t ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

>>> src/r2p_cordic_step.sv
`timescale 1ns / 1ps
// r2p_cordic_step: one registered CORDIC vectoring micro-rotation.
// Uses the arctangent table and turn type from r2p_pkg.

module r2p_cordic_step #(
    parameter int CW   = 43,
    parameter int STEP = 0
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [CW-1:0]  x_in,
    input  logic signed [CW-1:0]  y_in,
    input  r2p_pkg::turn_t        acc_in,
    output logic signed [CW-1:0]  x_out,
    output logic signed [CW-1:0]  y_out,
    output r2p_pkg::turn_t        acc_out
);
    import r2p_pkg::*;

    logic signed [CW-1:0] x_shr;
    logic signed [CW-1:0] y_shr;
    logic                 y_pos;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    turn_t                acc_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    turn_t                acc_reg;

    // Arithmetic shifts round toward minus infinity
    assign x_shr = x_in >>> STEP;
    assign y_shr = y_in >>> STEP;
    assign y_pos = !y_in[CW-1] && (y_in != '0);

    // Rotate toward the real axis; y == 0 takes the negative direction
    always_comb
    begin
        if (y_pos)
        begin
            x_next   = x_in + y_shr;
            y_next   = y_in - x_shr;
            acc_next = acc_in + ATAN_TURN[STEP];
        end
        else
        begin
            x_next   = x_in - y_shr;
            y_next   = y_in + x_shr;
            acc_next = acc_in - ATAN_TURN[STEP];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign acc_out = acc_reg;

endmodule

>>> src/r2p_sqrt_step.sv
`timescale 1ns / 1ps
// r2p_sqrt_step: one registered digit of the restoring integer square root.
// Standalone; sized by the sample width.

module r2p_sqrt_step #(
    parameter int DW   = 16,
    parameter int STEP = 0
) (
    input  logic            clk,
    input  logic            en,
    input  logic [2*DW-1:0] rem_in,
    input  logic [2*DW-1:0] root_in,
    output logic [2*DW-1:0] rem_out,
    output logic [2*DW-1:0] root_out
);
    localparam int SW = 2 * DW;
    // Trial bit for this digit: 4^(DW-1-STEP)
    localparam logic [SW-1:0] TRIAL_BIT = SW'(1) << (2 * (DW - 1 - STEP));

    logic [SW:0]   trial;
    logic          fits;
    logic [SW-1:0] rem_next;
    logic [SW-1:0] root_next;
    logic [SW-1:0] rem_reg;
    logic [SW-1:0] root_reg;

    assign trial = {1'b0, root_in} + {1'b0, TRIAL_BIT};
    assign fits  = {1'b0, rem_in} >= trial;

    // Subtract the trial value when it fits and set the root digit
    always_comb
    begin
        if (fits)
        begin
            rem_next  = rem_in - trial[SW-1:0];
            root_next = (root_in >> 1) + TRIAL_BIT;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;

endmodule

>>> src/rectangular_to_polar.sv
`timescale 1ns / 1ps
// rectangular_to_polar: streaming complex-to-magnitude/phase converter, top level.
// Depends on r2p_pkg, r2p_cordic_step and r2p_sqrt_step.
//
// Usage:
//   Slave side (s_tvalid/s_tready/s_tdata) takes one complex sample per beat:
//   real_part in the low DATA_WIDTH bits, imag_part above it, both signed.
//   Master side (m_tvalid/m_tready/m_tdata) returns one beat per sample:
//   magnitude = round(sqrt(re^2 + im^2)) in the low DATA_WIDTH bits, then the
//   phase as an unsigned fraction of a turn (2^ANGLE_WIDTH = 2*pi).
//   Throughput: one sample per clock, sustained while m_tready is high.
//   Pipeline: one prep stage, one squaring stage, 32 CORDIC stages (one
//   micro-rotation each, with the square root digits run alongside), then
//   the output register that drives m_tvalid.
//   Reset clears all valid bits; s_tready is high right after reset.
//   When m_tready is low, a one-beat skid register catches the beat leaving
//   the pipeline; while it is full the whole pipeline holds and s_tready is
//   low. Nothing is dropped or repeated.

module rectangular_to_polar #(
    parameter int DATA_WIDTH  = 16,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // [DATA_WIDTH-1:0] real_part, [2*DATA_WIDTH-1:DATA_WIDTH] imag_part, zero pad above
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // [DATA_WIDTH-1:0] magnitude, [DATA_WIDTH+ANGLE_WIDTH-1:DATA_WIDTH] angle, zero pad above
    output logic [((DATA_WIDTH+ANGLE_WIDTH+7)/8)*8-1:0] m_tdata
);
    import r2p_pkg::*;

    localparam int DW       = DATA_WIDTH;
    localparam int AW       = ANGLE_WIDTH;
    localparam int SW       = 2 * DW;
    localparam int OW       = ((DW + AW + 7) / 8) * 8;
    localparam int CW       = DW + PRESCALE_BITS + HEADROOM_BITS;
    localparam int NSTEP    = CORDIC_STEPS;
    localparam int ROUND_SH = 32 - AW;
    localparam logic [32:0]   ROUND_HALF    = (33'd1 << ROUND_SH) >> 1;
    localparam logic [AW-1:0] QUARTER_TURN  = {2'b01, {(AW-2){1'b0}}};
    localparam logic [AW-1:0] HALF_TURN     = {2'b10, {(AW-2){1'b0}}};
    localparam logic [AW-1:0] THREE_QUARTER = {2'b11, {(AW-2){1'b0}}};

    // Pipeline enable: everything advances unless the skid register is full
    logic en;

    // ---------------- prep (comb from the slave beat) ----------------
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic signed [DW:0]   re_ext;
    logic signed [DW:0]   im_ext;
    logic signed [DW:0]   nx;
    logic signed [DW:0]   ny;
    logic                 x_neg;
    logic                 y_neg;
    logic                 x_zero;
    logic                 y_zero;
    logic                 spec_in;
    logic [AW-1:0]        sang_in;

    assign re     = signed'(s_tdata[DW-1:0]);
    assign im     = signed'(s_tdata[SW-1:DW]);
    assign re_ext = {re[DW-1], re};
    assign im_ext = {im[DW-1], im};
    assign x_neg  = re[DW-1];
    assign y_neg  = im[DW-1];
    assign x_zero = (re == '0);
    assign y_zero = (im == '0);

    // Left half plane is turned by a half turn before the rotations
    assign nx = x_neg ? -re_ext : re_ext;
    assign ny = x_neg ? -im_ext : im_ext;

    // Axis and origin cases bypass the CORDIC result
    assign spec_in = x_zero || y_zero;
    always_comb
    begin
        if (x_zero)
        begin
            if (y_zero)
                sang_in = '0;
            else if (y_neg)
                sang_in = THREE_QUARTER;
            else
                sang_in = QUARTER_TURN;
        end
        else
        begin
            sang_in = x_neg ? HALF_TURN : '0;
        end
    end

    // Stage A registers
    logic [DW-1:0]        ax_reg;
    logic [DW-1:0]        ay_reg;
    logic signed [CW-1:0] xa_reg;
    logic signed [CW-1:0] ya_reg;
    turn_t                acca_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg   <= nx[DW-1:0];
            ay_reg   <= im_ext[DW] ? DW'(-im_ext) : im_ext[DW-1:0];
            xa_reg   <= {{(CW-PRESCALE_BITS-DW-1){nx[DW]}}, nx, {PRESCALE_BITS{1'b0}}};
            ya_reg   <= {{(CW-PRESCALE_BITS-DW-1){ny[DW]}}, ny, {PRESCALE_BITS{1'b0}}};
            acca_reg <= x_neg ? ACC_HALF_TURN : '0;
        end
    end

    // ---------------- stage B: sum of squares ----------------
    logic [SW-1:0]        sqx;
    logic [SW-1:0]        sqy;
    logic [SW-1:0]        remb_reg;
    logic signed [CW-1:0] xb_reg;
    logic signed [CW-1:0] yb_reg;
    turn_t                accb_reg;

    assign sqx = SW'(ax_reg) * SW'(ax_reg);
    assign sqy = SW'(ay_reg) * SW'(ay_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            remb_reg <= sqx + sqy;
            xb_reg   <= xa_reg;
            yb_reg   <= ya_reg;
            accb_reg <= acca_reg;
        end
    end

    // ---------------- iteration stages ----------------
    logic signed [CW-1:0] cx_pipe   [NSTEP+1];
    logic signed [CW-1:0] cy_pipe   [NSTEP+1];
    turn_t                acc_pipe  [NSTEP+1];
    logic [SW-1:0]        rem_pipe  [NSTEP+1];
    logic [SW-1:0]        root_pipe [NSTEP+1];

    assign cx_pipe[0]   = xb_reg;
    assign cy_pipe[0]   = yb_reg;
    assign acc_pipe[0]  = accb_reg;
    assign rem_pipe[0]  = remb_reg;
    assign root_pipe[0] = '0;

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_stage
        r2p_cordic_step #(
            .CW   (CW),
            .STEP (k)
        ) u_cordic (
            .clk     (clk),
            .en      (en),
            .x_in    (cx_pipe[k]),
            .y_in    (cy_pipe[k]),
            .acc_in  (acc_pipe[k]),
            .x_out   (cx_pipe[k+1]),
            .y_out   (cy_pipe[k+1]),
            .acc_out (acc_pipe[k+1])
        );

        if (k < DW)
        begin : g_sqrt
            r2p_sqrt_step #(
                .DW   (DW),
                .STEP (k)
            ) u_sqrt (
                .clk      (clk),
                .en       (en),
                .rem_in   (rem_pipe[k]),
                .root_in  (root_pipe[k]),
                .rem_out  (rem_pipe[k+1]),
                .root_out (root_pipe[k+1])
            );
        end
        else
        begin : g_hold
            // Root is complete; delay it to line up with the phase
            logic [SW-1:0] rem_hold_reg;
            logic [SW-1:0] root_hold_reg;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_hold_reg  <= rem_pipe[k];
                    root_hold_reg <= root_pipe[k];
                end
            end

            assign rem_pipe[k+1]  = rem_hold_reg;
            assign root_pipe[k+1] = root_hold_reg;
        end
    end

    // ---------------- valid and bypass delay lines ----------------
    // Bit 0 = stage A, bit 1 = stage B, bit k+2 = iteration stage k
    logic [NSTEP+1:0] vld_reg;
    logic [NSTEP+1:0] spec_reg;
    logic [AW-1:0]    sang_reg [NSTEP+2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTEP:0], s_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            spec_reg    <= {spec_reg[NSTEP:0], spec_in};
            sang_reg[0] <= sang_in;
            for (int i = 1; i < NSTEP + 2; i++)
                sang_reg[i] <= sang_reg[i-1];
        end
    end

    // ---------------- result rounding ----------------
    logic [32:0]   rnd_sum;
    logic [AW-1:0] cord_ang;
    logic [AW-1:0] ang_final;
    logic [SW-1:0] mag_full;
    logic [OW-1:0] res;

    assign rnd_sum   = {1'b0, acc_pipe[NSTEP]} + ROUND_HALF;
    assign cord_ang  = rnd_sum[ROUND_SH +: AW];
    assign ang_final = spec_reg[NSTEP+1] ? sang_reg[NSTEP+1] : cord_ang;
    // Round to nearest: bump when the remainder exceeds the root
    assign mag_full  = root_pipe[NSTEP]
                       + SW'(rem_pipe[NSTEP] > root_pipe[NSTEP]);
    assign res       = OW'({ang_final, mag_full[DW-1:0]});

    // ---------------- output register and skid ----------------
    logic          out_vld_reg;
    logic          out_vld_next;
    logic          skid_vld_reg;
    logic          skid_vld_next;
    logic [OW-1:0] out_dat_reg;
    logic [OW-1:0] skid_dat_reg;
    logic          out_free;
    logic          pipe_fire;

    assign en        = !skid_vld_reg;
    assign pipe_fire = en && vld_reg[NSTEP+1];
    assign out_free  = !out_vld_reg || m_tready;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (out_free)
        begin
            if (skid_vld_reg)
            begin
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = pipe_fire;
            end
        end
        else if (pipe_fire)
        begin
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
            out_dat_reg <= skid_vld_reg ? skid_dat_reg : res;
        else if (pipe_fire)
            skid_dat_reg <= res;
    end

    assign s_tready = en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;

`ifndef ASSERT_OFF
    // Skid holds a beat only behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full while output register empty");

    // A held pipeline keeps its oldest beat
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!en && vld_reg[NSTEP+1]) |=> vld_reg[NSTEP+1])
        else $error("pipeline beat lost during stall");

    // Skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && !m_tready))
        else $error("skid register filled without output stall");
`endif

endmodule

>>> tb/rectangular_to_polar_tb.sv
`timescale 1ns / 1ps
// rectangular_to_polar_tb: self-checking stream testbench for the magnitude/phase converter.
// Depends on rectangular_to_polar (and through it r2p_pkg); predicts every beat in place.

module rectangular_to_polar_tb;

    localparam int DATA_WIDTH  = 16;
    localparam int ANGLE_WIDTH = 16;
    localparam int CORDIC_STEPS = 32;
    localparam int PRESCALE_BITS = 24;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD = 250;
    localparam int DRAIN_CYCLES = 40;

    // fixed phase codes, in units of a full turn over 2^ANGLE_WIDTH
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_ZERO    = 16'h0000;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_QUARTER = 16'h4000;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_HALF    = 16'h8000;
    localparam logic [ANGLE_WIDTH-1:0] ANGLE_3QUARTER = 16'hC000;
    localparam logic [31:0] ACC_HALF = 32'h8000_0000;

    // round(atan(2^-i) / (2*pi) * 2^32)
    localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // idle / stall percentages per traffic phase
    localparam int SEND_IDLE [4] = '{0, 70, 0, 22};
    localparam int RECV_STALL [4] = '{0, 0, 70, 22};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] re;
        logic signed [DATA_WIDTH-1:0] im;
    } sample_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0]  magnitude;
        logic [ANGLE_WIDTH-1:0] angle;
    } polar_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [31:0] s_tdata = '0;   // [15:0] real_part, [31:16] imag_part
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [31:0] m_tdata;        // [15:0] magnitude, [31:16] angle

    sample_t samples_to_send[$];
    polar_t  awaited_polar[$];
    sample_t next_sample;
    polar_t  want;
    bit sample_taken = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int idle_cycles = 0;
    int errors = 0;

    rectangular_to_polar #(
        .DATA_WIDTH  (DATA_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // bitwise integer square root, rounded to nearest (ties up)
    function automatic logic [DATA_WIDTH-1:0] rounded_root(longint unsigned s);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s)
            b >>= 2;
        while (b != 0)
        begin
            if (s >= root + b)
            begin
                s -= root + b;
                root = (root >> 1) + b;
            end
            else
                root >>= 1;
            b >>= 2;
        end
        if (s > root)
            root++;
        return root[DATA_WIDTH-1:0];
    endfunction

    // vectoring CORDIC on a 32-bit turn accumulator, rounded half up to ANGLE_WIDTH
    function automatic logic [ANGLE_WIDTH-1:0] cordic_phase(longint x, longint y);
        logic [31:0] acc;
        logic [32:0] rounded;
        longint xs;
        longint ys;
        acc = '0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            acc = ACC_HALF;
        end
        x = x <<< PRESCALE_BITS;
        y = y <<< PRESCALE_BITS;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x += ys;
                y -= xs;
                acc += ATAN_TURNS[i];
            end
            else
            begin
                x -= ys;
                y += xs;
                acc -= ATAN_TURNS[i];
            end
        end
        // carry out of bit 31 is dropped: a near-full turn wraps to zero
        rounded = {1'b0, acc} + 33'(1 << (32 - ANGLE_WIDTH - 1));
        return rounded[31:32-ANGLE_WIDTH];
    endfunction

    function automatic polar_t polar_of(logic signed [DATA_WIDTH-1:0] re,
                                        logic signed [DATA_WIDTH-1:0] im);
        polar_t r;
        longint x;
        longint y;
        longint ax;
        longint ay;
        x = re;
        y = im;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        r.magnitude = rounded_root(longint'(ax * ax + ay * ay));
        if (x == 0)
            r.angle = (y > 0) ? ANGLE_QUARTER : (y < 0) ? ANGLE_3QUARTER : ANGLE_ZERO;
        else if (y == 0)
            r.angle = (x > 0) ? ANGLE_ZERO : ANGLE_HALF;
        else
            r.angle = cordic_phase(x, y);
        return r;
    endfunction

    task automatic queue_sample(int re, int im);
        sample_t s;
        s.re = 16'(re);
        s.im = 16'(im);
        samples_to_send.push_back(s);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        int kind;
        kind = $urandom_range(0, 9);
        s.re = 16'($urandom);
        s.im = 16'($urandom);
        case (kind)
            5, 6:
            begin
                // tiny vectors: coarse angles, rounding of small roots
                s.re = 16'($urandom_range(0, 8)) - 16'd4;
                s.im = 16'($urandom_range(0, 8)) - 16'd4;
            end
            7:
            begin
                if ($urandom_range(0, 1))
                    s.re = '0;
                else
                    s.im = '0;
            end
            8:
            begin
                s.re = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7FFF;
                if ($urandom_range(0, 1))
                    s.im = ($urandom_range(0, 1)) ? 16'sh8000 : 16'sh7FFF;
            end
            9:
            begin
                // on or next to the diagonals
                s.im = ($urandom_range(0, 1)) ? s.re : -s.re;
                s.im = s.im + 16'($urandom_range(0, 2)) - 16'sd1;
            end
            default: ;
        endcase
        return s;
    endfunction

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_tvalid || awaited_polar.size() != 0)
            @(posedge clk);
    endtask

    // beat driver: next sample goes out at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || sample_taken)
            begin
                if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_sample = samples_to_send.pop_front();
                    s_tdata <= {next_sample.im, next_sample.re};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_left = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // accepted beats: predict on input, compare on output, watch for a hang
    always @(posedge clk)
    begin
        sample_taken = rst_n && s_tvalid && s_tready;
        if (sample_taken)
            awaited_polar.push_back(polar_of(s_tdata[15:0], s_tdata[31:16]));
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_polar.size() == 0)
            begin
                $error("result beat with nothing pending: %h", m_tdata);
                errors++;
            end
            else
            begin
                want = awaited_polar.pop_front();
                if (m_tdata[15:0] !== want.magnitude)
                begin
                    $error("magnitude: expected %0d, got %0d", want.magnitude, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[31:16] !== want.angle)
                begin
                    $error("angle: expected %0d, got %0d", want.angle, m_tdata[31:16]);
                    errors++;
                end
            end
        end
        if (sample_taken || (rst_n && m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: origin, axes, extremes, quadrants, wrap past a full turn
        queue_sample(0, 0);
        queue_sample(0, 1);
        queue_sample(0, -1);
        queue_sample(0, 32767);
        queue_sample(0, -32768);
        queue_sample(1, 0);
        queue_sample(-1, 0);
        queue_sample(32767, 0);
        queue_sample(-32768, 0);
        queue_sample(32767, 32767);
        queue_sample(-32768, -32768);
        queue_sample(-32768, 32767);
        queue_sample(32767, -32768);
        queue_sample(1, 1);
        queue_sample(-1, 1);
        queue_sample(-1, -1);
        queue_sample(1, -1);
        queue_sample(32767, -1);
        queue_sample(-32768, 1);
        queue_sample(-32768, -1);
        queue_sample(3, 4);
        queue_sample(-21846, 10923);
        wait_drained();

        // random traffic under each idling phase
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            repeat (110) samples_to_send.push_back(random_sample());
            while (samples_to_send.size() != 0)
                @(posedge clk);
        end
        wait_drained();

        // long receiver hold-off while the sender keeps pushing: pipeline fills
        send_idle_pct = 0;
        stall_pct = 0;
        @(posedge clk);
        hold_req = 1'b1;
        repeat (70) samples_to_send.push_back(random_sample());
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && awaited_polar.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
